@@ design/dsmv_pkg.sv @@
// Shared package for the DIA sparse matrix-vector multiply block.
// Holds item codes, register indexes, reset values and the control structs.
// No dependencies.
`timescale 1ns / 1ps
package dsmv_pkg;

  // Item command codes
  localparam logic [2:0] CMD_OFFSET = 3'd0;
  localparam logic [2:0] CMD_DIAG   = 3'd1;
  localparam logic [2:0] CMD_X      = 3'd2;
  localparam logic [2:0] CMD_Y      = 3'd3;
  localparam logic [2:0] CMD_RUN    = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] CFG_ALPHA     = 8'd0;
  localparam logic [7:0] CFG_BETA      = 8'd1;
  localparam logic [7:0] CFG_NUM_ROWS  = 8'd2;
  localparam logic [7:0] CFG_NUM_DIAGS = 8'd3;

  // Register reset values
  localparam logic signed [31:0] ALPHA_RESET     = 32'sd65536;
  localparam logic signed [31:0] BETA_RESET      = 32'sd0;
  localparam logic [10:0]        NUM_ROWS_RESET  = 11'd1024;
  localparam logic [4:0]         NUM_DIAGS_RESET = 5'd0;

  // Default storage sizes
  localparam int DEF_MAX_ROWS  = 1024;
  localparam int DEF_MAX_DIAGS = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store the accepted load item
    logic rd_in;      // read y at the item's row
    logic rd_y;       // read y at the walk row
    logic rd_elem;    // read diagonal value, x and y for one element
    logic beta_mul;   // product = beta * y
    logic alpha_mul;  // product = alpha * value
    logic x_mul;      // product = sat(product >> 16) * x
    logic wr_beta;    // y = sat(product >> 16)
    logic wr_acc;     // y = sat(y + (product >> 16))
    logic out_read;   // load the output register with read data
    logic out_done;   // load the output register with run complete
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic               out_free;
    logic signed [10:0] offset;
  } stat_t;

endpackage

@@ design/dsmv_dpath.sv @@
// Datapath: offset, diagonal, x and y stores, the shared multiplier and the
// output register. Depends on dsmv_pkg; driven by dsmv_ctrl.
`timescale 1ns / 1ps
module dsmv_dpath #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_DIAGS = 16,
  parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int DW = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  dsmv_pkg::ctl_t     ctl,
  output dsmv_pkg::stat_t    stat,
  input  logic [RW-1:0]      row_addr,
  input  logic [RW-1:0]      col_addr,
  input  logic [DW-1:0]      diag_addr,
  input  logic signed [31:0] alpha,
  input  logic signed [31:0] beta,
  input  logic [2:0]         cmd,
  input  logic [3:0]         diag_index,
  input  logic [9:0]         row_index,
  input  logic signed [31:0] data_value,
  input  logic signed [10:0] diag_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic [9:0]         result_row,
  output logic signed [31:0] y_value
);
  import dsmv_pkg::*;

  localparam int DEPTH = MAX_DIAGS * MAX_ROWS;
  localparam int DAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [10:0] offset_store [MAX_DIAGS];
  logic signed [31:0] diag_store [DEPTH];
  logic signed [31:0] x_store [MAX_ROWS];
  logic signed [31:0] y_store [MAX_ROWS];

  logic signed [31:0] v_rd, x_rd, y_rd;
  logic signed [63:0] prod;
  logic [9:0]         rd_row;
  logic               rd_ok;

  logic               row_ok, diag_ok;
  logic [RW-1:0]      in_row;
  logic [DW-1:0]      in_diag;
  logic [DAW-1:0]     load_daddr, walk_daddr;
  logic               y_we;
  logic [RW-1:0]      y_waddr, y_raddr;
  logic signed [31:0] y_wdata;
  logic signed [31:0] term, mul_a, mul_b;
  logic signed [47:0] prod_sh;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Address decode of the accepted item
  assign row_ok     = (int'(row_index) < MAX_ROWS);
  assign diag_ok    = (int'(diag_index) < MAX_DIAGS);
  assign in_row     = RW'(row_index);
  assign in_diag    = DW'(diag_index);
  assign load_daddr = DAW'(DAW'(in_diag) * DAW'(MAX_ROWS)) + DAW'(in_row);
  assign walk_daddr = DAW'(DAW'(diag_addr) * DAW'(MAX_ROWS)) + DAW'(row_addr);

  // Offset store, read at the diagonal under walk
  always_ff @(posedge clk) begin
    if (ctl.load && cmd == CMD_OFFSET && diag_ok) begin
      offset_store[in_diag] <= diag_offset;
    end
  end
  assign stat.offset = offset_store[diag_addr];

  // Diagonal data store
  always_ff @(posedge clk) begin
    if (ctl.load && cmd == CMD_DIAG && diag_ok && row_ok) begin
      diag_store[load_daddr] <= data_value;
    end
    if (ctl.rd_elem) begin
      v_rd <= diag_store[walk_daddr];
    end
  end

  // x store
  always_ff @(posedge clk) begin
    if (ctl.load && cmd == CMD_X && row_ok) begin
      x_store[in_row] <= data_value;
    end
    if (ctl.rd_elem) begin
      x_rd <= x_store[col_addr];
    end
  end

  // Shared multiplier and result shaping
  assign prod_sh = prod[63:16];
  assign term    = sat32(65'(prod_sh));
  always_comb begin
    mul_a = beta;
    mul_b = y_rd;
    if (ctl.alpha_mul) begin
      mul_a = alpha;
      mul_b = v_rd;
    end else if (ctl.x_mul) begin
      mul_a = term;
      mul_b = x_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.beta_mul || ctl.alpha_mul || ctl.x_mul) begin
      prod <= mul_a * mul_b;
    end
  end

  // y store: one write port, one read port
  always_comb begin
    y_we    = 1'b0;
    y_waddr = row_addr;
    y_wdata = term;
    y_raddr = row_addr;
    if (ctl.load && cmd == CMD_Y && row_ok) begin
      y_we    = 1'b1;
      y_waddr = in_row;
      y_wdata = data_value;
    end else if (ctl.wr_beta) begin
      y_we = 1'b1;
    end else if (ctl.wr_acc) begin
      y_we    = 1'b1;
      y_wdata = sat32(65'(y_rd) + 65'(prod_sh));
    end
    if (ctl.rd_in) begin
      y_raddr = in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      y_store[y_waddr] <= y_wdata;
    end
    if (ctl.rd_in || ctl.rd_y || ctl.rd_elem) begin
      y_rd <= y_store[y_raddr];
    end
    if (ctl.rd_in) begin
      rd_row <= row_index;
      rd_ok  <= row_ok;
    end
  end

  // Output register
  assign stat.out_free = !out_valid || !out_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_read || ctl.out_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_read) begin
      result_kind <= KIND_READ;
      result_row  <= rd_row;
      y_value     <= rd_ok ? y_rd : 32'sd0;
    end else if (ctl.out_done) begin
      result_kind <= KIND_DONE;
      result_row  <= '0;
      y_value     <= 32'sd0;
    end
  end

endmodule

@@ design/dsmv_ctrl.sv @@
// Controller: item decode and the state machine that walks the beta pass
// and every diagonal element. Depends on dsmv_pkg; drives dsmv_dpath.
`timescale 1ns / 1ps
module dsmv_ctrl #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_DIAGS = 16,
  parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int DW = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      cmd,
  input  logic [10:0]     row_count,
  input  logic [4:0]      num_diags,
  input  dsmv_pkg::stat_t stat,
  output dsmv_pkg::ctl_t  ctl,
  output logic [RW-1:0]   row_addr,
  output logic [RW-1:0]   col_addr,
  output logic [DW-1:0]   diag_addr
);
  import dsmv_pkg::*;

  localparam int NW  = $clog2(MAX_ROWS + 1);
  localparam int DCW = $clog2(MAX_DIAGS + 1);
  localparam int CW  = ((NW > 11) ? NW : 11) + 2;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_READ    = 4'd1;
  localparam logic [3:0] S_B_RD    = 4'd2;
  localparam logic [3:0] S_B_MUL   = 4'd3;
  localparam logic [3:0] S_B_WR    = 4'd4;
  localparam logic [3:0] S_D_SETUP = 4'd5;
  localparam logic [3:0] S_E_RD    = 4'd6;
  localparam logic [3:0] S_E_M1    = 4'd7;
  localparam logic [3:0] S_E_M2    = 4'd8;
  localparam logic [3:0] S_E_WR    = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]           state, state_next;
  logic signed [CW-1:0] row, row_end;
  logic [DCW-1:0]       diag;
  logic                 acc;
  logic [NW-1:0]        n_eff;
  logic [DCW-1:0]       nd_eff;
  logic signed [CW-1:0] n_s, off_s, start_s, end_s;

  // Effective sizes and the row range of the current diagonal
  assign n_eff   = (32'(row_count) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(row_count);
  assign nd_eff  = (32'(num_diags) > MAX_DIAGS) ? DCW'(MAX_DIAGS) : DCW'(num_diags);
  assign n_s     = CW'(n_eff);
  assign off_s   = CW'(stat.offset);
  assign start_s = (off_s < 0) ? -off_s : '0;
  assign end_s   = (off_s > 0) ? n_s - off_s : n_s;

  assign in_stall  = (state != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign row_addr  = RW'(row);
  assign col_addr  = RW'(row + off_s);
  assign diag_addr = diag[DW-1:0];

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (cmd)
            CMD_OFFSET, CMD_DIAG, CMD_X, CMD_Y: ctl.load = 1'b1;
            CMD_READ: begin
              ctl.rd_in  = 1'b1;
              state_next = S_READ;
            end
            CMD_RUN: state_next = S_B_RD;
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          ctl.out_read = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_B_RD: begin
        if (row >= n_s) begin
          state_next = S_D_SETUP;
        end else begin
          ctl.rd_y   = 1'b1;
          state_next = S_B_MUL;
        end
      end
      S_B_MUL: begin
        ctl.beta_mul = 1'b1;
        state_next   = S_B_WR;
      end
      S_B_WR: begin
        ctl.wr_beta = 1'b1;
        state_next  = S_B_RD;
      end
      S_D_SETUP: begin
        state_next = (diag >= nd_eff) ? S_DONE : S_E_RD;
      end
      S_E_RD: begin
        if (row >= row_end) begin
          state_next = S_D_SETUP;
        end else begin
          ctl.rd_elem = 1'b1;
          state_next  = S_E_M1;
        end
      end
      S_E_M1: begin
        ctl.alpha_mul = 1'b1;
        state_next    = S_E_M2;
      end
      S_E_M2: begin
        ctl.x_mul  = 1'b1;
        state_next = S_E_WR;
      end
      S_E_WR: begin
        ctl.wr_acc = 1'b1;
        state_next = S_E_RD;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.out_done = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Row and diagonal counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      row_end <= '0;
      diag    <= '0;
    end else begin
      if (state == S_IDLE) begin
        row  <= '0;
        diag <= '0;
      end
      if (state == S_B_WR || state == S_E_WR) begin
        row <= row + CW'(1);
      end
      if (state == S_D_SETUP) begin
        row     <= start_s;
        row_end <= end_s;
      end
      if (state == S_E_RD && row >= row_end) begin
        diag <= diag + DCW'(1);
      end
    end
  end

endmodule

@@ design/dia_sparse_matrix_vector_multiply.sv @@
// Load items (offset, diagonal data, x, y) are stored at the edge that accepts them.
// A read item reads y at acceptance and loads its result into the output register from the
// read state once it is free. A run loads its result once the beta pass and all diagonals
// are walked: the shared 32x32 multiplier and the single y memory port serve one element
// at a time. One item is worked at a time. Synchronous reset clears control state and sets
// the registers to alpha 1.0, beta 0, 1024 rows and no diagonals; stores are not cleared.
`timescale 1ns / 1ps
module dia_sparse_matrix_vector_multiply #(
  parameter int MAX_ROWS  = dsmv_pkg::DEF_MAX_ROWS,
  parameter int MAX_DIAGS = dsmv_pkg::DEF_MAX_DIAGS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic [3:0]         diag_index,
  input  logic [9:0]         row_index,
  input  logic signed [31:0] data_value,
  input  logic signed [10:0] diag_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic [9:0]         result_row,
  output logic signed [31:0] y_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import dsmv_pkg::*;

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DW = (MAX_DIAGS > 1) ? $clog2(MAX_DIAGS) : 1;

  logic signed [31:0] alpha, beta;
  logic [10:0]        row_count;
  logic [4:0]         num_diags;
  ctl_t               ctl;
  stat_t              stat;
  logic [RW-1:0]      row_addr, col_addr;
  logic [DW-1:0]      diag_addr;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha     <= ALPHA_RESET;
      beta      <= BETA_RESET;
      row_count <= NUM_ROWS_RESET;
      num_diags <= NUM_DIAGS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA:     alpha     <= cfg_data;
        CFG_BETA:      beta      <= cfg_data;
        CFG_NUM_ROWS:  row_count <= cfg_data[10:0];
        CFG_NUM_DIAGS: num_diags <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Controller
  dsmv_ctrl #(
    .MAX_ROWS(MAX_ROWS), .MAX_DIAGS(MAX_DIAGS), .RW(RW), .DW(DW)
  ) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .row_count(row_count), .num_diags(num_diags), .stat(stat), .ctl(ctl),
    .row_addr(row_addr), .col_addr(col_addr), .diag_addr(diag_addr)
  );

  // Datapath
  dsmv_dpath #(
    .MAX_ROWS(MAX_ROWS), .MAX_DIAGS(MAX_DIAGS), .RW(RW), .DW(DW)
  ) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .stat(stat), .row_addr(row_addr),
    .col_addr(col_addr), .diag_addr(diag_addr), .alpha(alpha), .beta(beta),
    .cmd(cmd), .diag_index(diag_index), .row_index(row_index),
    .data_value(data_value), .diag_offset(diag_offset), .out_valid(out_valid),
    .out_stall(out_stall), .result_kind(result_kind), .result_row(result_row),
    .y_value(y_value)
  );

  // A run complete result carries zero row and value.
  a_done_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_DONE |-> result_row == '0 && y_value == '0)
    else $error("run complete result with nonzero payload");

  // Run and read items hold off the next item.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (cmd == CMD_RUN || cmd == CMD_READ) |=> in_stall)
    else $error("input taken while an item is at work");

  // The output register is loaded only when it is free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_read || ctl.out_done) |-> !out_valid || !out_stall)
    else $error("output register overwritten");

endmodule

@@ verif/tb_dia_sparse_matrix_vector_multiply.sv @@
// Self-checking testbench for the DIA sparse matrix-vector multiply block.
// Depends on dsmv_pkg and dia_sparse_matrix_vector_multiply; holds its own predictor.
// A queue-fed driver, a monitor and random stalls on both item channels.
`timescale 1ns / 1ps
module tb_dia_sparse_matrix_vector_multiply;
  import dsmv_pkg::*;

  localparam int ROWS  = 1024;
  localparam int DIAGS = 16;
  // Rows 0 to FILL of x, y and the diagonal data are filled at start; every run
  // walk and every random read stays inside them.
  localparam int FILL  = 8;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         di;
    logic [9:0]         row;
    logic signed [31:0] val;
    logic signed [10:0] off;
  } item_t;

  typedef struct {
    logic               kind;
    logic [9:0]         row;
    logic signed [31:0] yv;
  } yres_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         cmd;
  logic [3:0]         diag_index;
  logic [9:0]         row_index;
  logic signed [31:0] data_value;
  logic signed [10:0] diag_offset;
  logic               out_valid;
  logic               out_stall;
  logic               result_kind;
  logic [9:0]         result_row;
  logic signed [31:0] y_value;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [31:0]        cfg_data;

  dia_sparse_matrix_vector_multiply uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .diag_index(diag_index), .row_index(row_index),
    .data_value(data_value), .diag_offset(diag_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .result_row(result_row), .y_value(y_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: registers and the four stores.
  longint             alpha_q;
  longint             beta_q;
  logic [10:0]        rows_q;
  logic [4:0]         diags_q;
  logic signed [10:0] offs_q [DIAGS];
  logic signed [31:0] diag_q [DIAGS*ROWS];
  logic signed [31:0] x_q [ROWS];
  logic signed [31:0] y_q [ROWS];

  item_t pending [$];
  yres_t y_expect [$];
  int    errors;
  bit    calm;
  int    in_gap;
  int    out_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product of two values, truncated toward minus infinity.
  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  // y = beta*y, then y[i] += alpha*val*x[i+off] over every diagonal in use.
  task automatic spmv_update();
    longint n;
    longint nd;
    longint o;
    longint lo;
    longint hi;
    longint t;
    n = (rows_q > ROWS) ? ROWS : rows_q;
    nd = (diags_q > DIAGS) ? DIAGS : diags_q;
    for (int i = 0; i < n; i++) y_q[i] = sat32(qmul(beta_q, y_q[i]));
    for (int d = 0; d < nd; d++) begin
      o = offs_q[d];
      lo = (o < 0) ? -o : 0;
      hi = (o > 0) ? n - o : n;
      for (longint i = lo; i < hi; i++) begin
        t = sat32(qmul(alpha_q, diag_q[d*ROWS + i]));
        y_q[i] = sat32(longint'(y_q[i]) + qmul(t, x_q[i + o]));
      end
    end
  endtask

  // Apply one accepted item to the predictor and queue any result it causes.
  task automatic predict_item();
    yres_t r;
    case (cmd)
      CMD_OFFSET: offs_q[diag_index] = diag_offset;
      CMD_DIAG:   diag_q[diag_index*ROWS + row_index] = data_value;
      CMD_X:      x_q[row_index] = data_value;
      CMD_Y:      y_q[row_index] = data_value;
      CMD_RUN: begin
        spmv_update();
        r.kind = KIND_DONE;
        r.row = '0;
        r.yv = '0;
        y_expect.push_back(r);
      end
      CMD_READ: begin
        r.kind = KIND_READ;
        r.row = row_index;
        r.yv = y_q[row_index];
        y_expect.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: takes the next pending item, with random idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) predict_item();
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          item_t it;
          it = pending.pop_front();
          cmd <= it.op;
          diag_index <= it.di;
          row_index <= it.row;
          data_value <= it.val;
          diag_offset <= it.off;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall bursts and a field-by-field check of each result.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (y_expect.size() == 0) begin
          report("unexpected result", result_kind, -1);
        end else begin
          yres_t e;
          e = y_expect.pop_front();
          if (result_kind !== e.kind) report("result_kind", result_kind, e.kind);
          if (result_row !== e.row) report("result_row", result_row, e.row);
          if (y_value !== e.yv) report("y_value", y_value, e.yv);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA:     alpha_q = longint'($signed(value));
      CFG_BETA:      beta_q = longint'($signed(value));
      CFG_NUM_ROWS:  rows_q = value[10:0];
      CFG_NUM_DIAGS: diags_q = value[4:0];
      default: ;
    endcase
  endtask

  task automatic push(logic [2:0] op, int di, int row, logic [31:0] val, int off);
    item_t it;
    it.op = op;
    it.di = di;
    it.row = row;
    it.val = val;
    it.off = off;
    pending.push_back(it);
  endtask

  // Wait until every item is sent and every result is back, then let the block settle.
  task automatic drain();
    do @(posedge clk); while (pending.size() > 0 || in_valid || y_expect.size() > 0);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 1 << 19) - (1 << 18);
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return $urandom;
      default: return $urandom_range(0, 1 << 18) - (1 << 17);
    endcase
  endfunction

  // Random items for one setting; diagonal walks and reads stay within the filled rows.
  task automatic random_items(int count, int n);
    int r;
    int off;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) off = $urandom_range(0, 2047);
      else off = $urandom_range(0, 2 * n) - n;
      if (r < 35)
        push(CMD_DIAG, $urandom_range(0, 15),
             ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROWS - 1) : $urandom_range(0, n),
             rand_q(), off);
      else if (r < 47) push(CMD_X, $urandom_range(0, 15), $urandom_range(0, ROWS - 1),
                            rand_q(), off);
      else if (r < 57) push(CMD_Y, $urandom_range(0, 15), $urandom_range(0, ROWS - 1),
                            rand_q(), off);
      else if (r < 67) push(CMD_OFFSET, $urandom_range(0, 15), $urandom_range(0, ROWS - 1),
                            $urandom, off);
      else if (r < 77) push(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, ROWS - 1),
                            $urandom, off);
      else if (r < 97) push(CMD_READ, $urandom_range(0, 15), $urandom_range(0, FILL),
                            $urandom, off);
      else push($urandom_range(6, 7), $urandom_range(0, 15), $urandom_range(0, ROWS - 1),
                $urandom, off);
    end
  endtask

  initial begin
    int n;
    errors = 0;
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    cmd = CMD_READ;
    diag_index = '0;
    row_index = '0;
    data_value = '0;
    diag_offset = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    alpha_q = ALPHA_RESET;
    beta_q = BETA_RESET;
    rows_q = NUM_ROWS_RESET;
    diags_q = NUM_DIAGS_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Keep runs inside the filled rows from the start.
    write_reg(CFG_NUM_ROWS, FILL + 1);

    // Fill the low rows of y, x and the diagonal data, and every offset.
    for (int i = 0; i <= FILL; i++) push(CMD_Y, 0, i, rand_q(), 0);
    for (int d = 0; d < DIAGS; d++) push(CMD_OFFSET, d, 0, 0, $urandom_range(0, 6) - 3);
    for (int i = 0; i <= FILL; i++) push(CMD_X, 0, i, rand_q(), 0);
    for (int d = 0; d < DIAGS; d++)
      for (int i = 0; i <= FILL; i++) push(CMD_DIAG, d, i, rand_q(), 0);
    // A run at reset scales: no diagonals, beta zero.
    push(CMD_RUN, 0, 0, 0, 0);
    push(CMD_READ, 0, FILL, 0, 0);
    drain();

    // Directed: extreme values, far offsets, saturation and unused commands.
    write_reg(CFG_ALPHA, 32'h7fff_ffff);
    write_reg(CFG_BETA, 32'h8000_0000);
    write_reg(CFG_NUM_ROWS, 11'd4);
    write_reg(CFG_NUM_DIAGS, 5'd3);
    push(CMD_OFFSET, 0, 0, 0, -1024);
    push(CMD_OFFSET, 1, 0, 0, 1023);
    push(CMD_OFFSET, 2, 0, 0, 1);
    push(CMD_DIAG, 2, 0, 32'h8000_0000, 0);
    push(CMD_DIAG, 2, 1, 32'h7fff_ffff, 0);
    push(CMD_X, 0, 1, 32'h7fff_ffff, 0);
    push(CMD_X, 0, 2, 32'h8000_0000, 0);
    push(CMD_Y, 0, 0, 32'h8000_0000, 0);
    push(CMD_Y, 0, 1, 32'h7fff_ffff, 0);
    push(CMD_Y, 15, ROWS - 1, 32'hffff_ffff, -1);
    push(3'd6, 15, ROWS - 1, 32'hffff_ffff, -1);
    push(3'd7, 0, 0, 0, 0);
    push(CMD_RUN, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) push(CMD_READ, 0, i, 0, 0);
    push(CMD_READ, 0, ROWS - 1, 0, 0);
    drain();

    // Size edges: no rows with an oversize diagonal count, then a beta-only
    // pass over every filled row.
    write_reg(CFG_NUM_ROWS, 11'd0);
    write_reg(CFG_NUM_DIAGS, 5'd31);
    push(CMD_RUN, 0, 0, 0, 0);
    push(CMD_READ, 0, 0, 0, 0);
    drain();
    write_reg(CFG_NUM_ROWS, FILL + 1);
    write_reg(CFG_NUM_DIAGS, 5'd0);
    write_reg(CFG_BETA, 32'h0001_8000);
    push(CMD_RUN, 0, 0, 0, 0);
    push(CMD_READ, 0, FILL, 0, 0);
    drain();

    // Random phases, each with its own setting; the last runs with no idling.
    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 10) calm = 1'b1;
      n = (ph == 3) ? FILL : $urandom_range(1, FILL);
      write_reg(CFG_ALPHA, rand_scale());
      write_reg(CFG_BETA, rand_scale());
      write_reg(CFG_NUM_ROWS, n);
      write_reg(CFG_NUM_DIAGS, (ph == 3) ? 16 : $urandom_range(0, 31));
      random_items(32, n);
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
